/* src/wlrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlrc_pkg: shared types and constants for the lag-one return correlator
// Sequencer states, window sum update modes, divider command and the fixed
// widths and limits of the register port and result fields.
// ----------------------------------------------------------------------------
package wlrc_pkg;

   // register port
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_INDEX_BITS = 1;
   localparam logic [REG_INDEX_BITS-1:0] REG_WINDOW = 1'b0;

   // window length register
   localparam int WINDOW_BITS = 9;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 9'd64;
   localparam logic [WINDOW_BITS-1:0] WINDOW_MIN   = 9'd4;
   localparam logic [WINDOW_BITS-1:0] WINDOW_SHORT = 9'd64;

   // result fields
   localparam int RESULT_BITS = 16;
   localparam logic signed [RESULT_BITS-1:0] CORR_LIMIT = 16'sd16384;
   localparam logic [RESULT_BITS-1:0]        STR_LIMIT  = 16'd40960;

   // divider: quotient width, step counts and the strength prescale
   localparam int QUO_BITS  = 16;
   localparam int STEP_BITS = 5;
   localparam logic [STEP_BITS-1:0] CORR_STEPS = 5'd15;
   localparam logic [STEP_BITS-1:0] STR_STEPS  = 5'd16;
   localparam int STR_FRAC = 12;
   localparam int STR_PRE  = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_R,
      ST_MUL_L,
      ST_PLAN,
      ST_OLD_RD,
      ST_OLD_SUB,
      ST_STORE,
      ST_SWEEP,
      ST_CORR_START,
      ST_CORR_DIV,
      ST_STR_START,
      ST_STR_DIV,
      ST_DONE
   } wlrc_state_type;

   typedef enum logic [1:0] {
      MODE_GROW,
      MODE_SLIDE,
      MODE_REBUILD
   } wlrc_mode_type;

   typedef struct packed {
      logic                 start;
      logic [STEP_BITS-1:0] steps;
   } div_cmd_type;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int imin(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

endpackage

/* src/wlrc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlrc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wlrc_ram #(
   parameter int WIDTH = 99,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       write_en,
   input  logic [$clog2(DEPTH)-1:0]   write_addr,
   input  logic [WIDTH-1:0]           write_data,
   input  logic                       read_en,
   input  logic [$clog2(DEPTH)-1:0]   read_addr,
   output logic [WIDTH-1:0]           read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

/* src/wlrc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlrc_div: iterative restoring divider
// Produces one quotient bit per cycle. The partial remainder starts below the
// divisor; each step shifts in the next bit of the feed word.
// ----------------------------------------------------------------------------
module wlrc_div #(
   parameter int REM_BITS = 58
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wlrc_pkg::div_cmd_type             div_cmd,
   input  logic [REM_BITS-1:0]               rem_start,
   input  logic [REM_BITS-1:0]               divisor,
   input  logic [wlrc_pkg::QUO_BITS-1:0]     feed_start,
   output logic                              div_done,
   output logic [wlrc_pkg::QUO_BITS-1:0]     quotient
);
   import wlrc_pkg::*;

   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [REM_BITS-1:0]  den_ff, den_in;
   logic [QUO_BITS-1:0]  quo_ff, quo_in;
   logic [QUO_BITS-1:0]  feed_ff, feed_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_BITS:0]    trial;
   logic [REM_BITS:0]    diff;

   // load on start, then one compare-and-subtract per cycle
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      feed_in = feed_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, feed_ff[QUO_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      if (div_cmd.start) begin
         rem_in  = rem_start;
         den_in  = divisor;
         quo_in  = '0;
         feed_in = feed_start;
         cnt_in  = div_cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[REM_BITS-1:0];
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[REM_BITS-1:0];
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
         end
         feed_in = {feed_ff[QUO_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      feed_ff <= feed_in;
      cnt_ff  <= cnt_in;
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/windowed_lag1_return_correlation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_lag1_return_correlation: sliding-window lag-one return correlator
// Takes one price per item and returns the windowed lag-one correlation of
// price returns together with a capped strength figure.
// ----------------------------------------------------------------------------
// One item is in flight at a time; req_ready is low from acceptance until the
// result is loaded into the output register, which can still be waiting for
// rsp_ready while the next item is taken. The first two prices go straight to
// the done state with a not-ready result. For later items the shared
// multiplier forms the cross term and both squares, the ring update reads back
// the leaving term when the window slides and stores the new term, and the
// shared restoring divider makes up to two passes (15 then 16 quotient bits,
// one bit per cycle). After a change of the window length, unless the term
// count only grows by the new term, the first item rebuilds both window sums
// by reading the newest terms back from the ring, one entry per cycle through
// its single read port. The ring memory needs no clearing after reset.
module windowed_lag1_return_correlation #(
   parameter int MAX_WINDOW = 256,
   parameter int PRICE_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [PRICE_BITS-1:0]                req_price,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_ready_res,
   output logic signed [wlrc_pkg::RESULT_BITS-1:0] rsp_correlation,
   output logic [wlrc_pkg::RESULT_BITS-1:0]     rsp_strength,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wlrc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wlrc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [wlrc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import wlrc_pkg::*;

   localparam int RET_BITS    = PRICE_BITS + 1;
   localparam int PROD_BITS   = 2 * RET_BITS;
   localparam int CROSS_BITS  = 2 * PRICE_BITS + 1;
   localparam int ENERGY_BITS = 2 * PRICE_BITS + 2;
   localparam int RING_BITS   = CROSS_BITS + ENERGY_BITS;
   localparam int PTR_BITS    = $clog2(MAX_WINDOW);
   localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int SEEN_BITS   = $clog2(MAX_WINDOW + 3);
   localparam int CSUM_BITS   = imin(64, CROSS_BITS + PTR_BITS);
   localparam int ESUM_BITS   = imin(64, ENERGY_BITS + PTR_BITS);
   localparam int MAG10_BITS  = imin(64, CSUM_BITS + 4);
   localparam int REM_BITS    = imax(CSUM_BITS, ESUM_BITS);
   localparam int WCMP_BITS   = imax(WINDOW_BITS, COUNT_BITS);

   localparam logic [SEEN_BITS-1:0]  SEEN_MAX  = SEEN_BITS'(MAX_WINDOW + 2);
   localparam logic [SEEN_BITS-1:0]  SEEN_TWO  = SEEN_BITS'(2);
   localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(MAX_WINDOW - 1);
   localparam logic [WCMP_BITS-1:0]  WIN_CAP   = WCMP_BITS'(MAX_WINDOW);

   // state
   wlrc_state_type                 state_ff, state_in;
   wlrc_mode_type                  mode_ff, mode_in;
   logic [WINDOW_BITS-1:0]         window_ff, window_in;
   logic [PRICE_BITS-1:0]          last_price_ff, last_price_in;
   logic signed [RET_BITS-1:0]     last_return_ff, last_return_in;
   logic signed [RET_BITS-1:0]     prev_return_ff, prev_return_in;
   logic [SEEN_BITS-1:0]           seen_ff, seen_in;
   logic [COUNT_BITS-1:0]          count_ff, count_in;
   logic [PTR_BITS-1:0]            ptr_ff, ptr_in;
   logic signed [CSUM_BITS-1:0]    cross_sum_ff, cross_sum_in;
   logic [ESUM_BITS-1:0]           energy_sum_ff, energy_sum_in;
   logic signed [PROD_BITS-1:0]    prod_ff, prod_in;
   logic signed [CROSS_BITS-1:0]   cross_term_ff, cross_term_in;
   logic [ENERGY_BITS-1:0]         energy_term_ff, energy_term_in;
   logic [PTR_BITS-1:0]            sweep_addr_ff, sweep_addr_in;
   logic [COUNT_BITS-1:0]          sweep_cnt_ff, sweep_cnt_in;
   logic                           rd_pend_ff, rd_pend_in;
   logic                           rdy_ff, rdy_in;
   logic [RESULT_BITS-1:0]         corr_ff, corr_in;
   logic [RESULT_BITS-1:0]         str_ff, str_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_rdy_ff, rsp_rdy_in;
   logic [RESULT_BITS-1:0]         rsp_corr_ff, rsp_corr_in;
   logic [RESULT_BITS-1:0]         rsp_str_ff, rsp_str_in;

   // combinational datapath
   logic signed [RET_BITS-1:0]     new_return;
   logic signed [RET_BITS-1:0]     mul_a, mul_b;
   logic signed [PROD_BITS-1:0]    mul_p;
   logic [WCMP_BITS-1:0]           w_eff;
   logic [WCMP_BITS-1:0]           stored;
   logic [COUNT_BITS-1:0]          k_new;
   logic [PTR_BITS-1:0]            ptr_next;
   logic [PTR_BITS-1:0]            sweep_next;
   logic                           ram_we, ram_re;
   logic [PTR_BITS-1:0]            ram_raddr;
   logic [RING_BITS-1:0]           ram_wdata, ram_rdata;
   logic signed [CROSS_BITS-1:0]   rd_cross;
   logic [ENERGY_BITS-1:0]         rd_energy;
   logic signed [CSUM_BITS-1:0]    rd_cross_ext, new_cross_ext;
   logic [ESUM_BITS-1:0]           rd_energy_ext, new_energy_ext;
   logic                           neg;
   logic [CSUM_BITS-1:0]           mag;
   logic [MAG10_BITS-1:0]          mag10;
   logic [REM_BITS-1:0]            corr_rem0, str_rem0, den;
   div_cmd_type                    div_cmd;
   logic [REM_BITS-1:0]            div_rem;
   logic [QUO_BITS-1:0]            div_feed;
   logic                           div_done;
   logic [QUO_BITS-1:0]            quotient;
   logic                           csr_write;

   // step a ring index back by an offset of up to a full ring
   function automatic logic [PTR_BITS-1:0] ring_back(input logic [PTR_BITS-1:0] base,
                                                     input logic [COUNT_BITS-1:0] off);
      logic [COUNT_BITS:0] diff;
      diff = (COUNT_BITS+1)'(base) - (COUNT_BITS+1)'(off);
      if ((COUNT_BITS+1)'(off) > (COUNT_BITS+1)'(base)) begin
         diff = diff + (COUNT_BITS+1)'(MAX_WINDOW);
      end
      return diff[PTR_BITS-1:0];
   endfunction

   // shared multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = last_return_ff;
      mul_b = prev_return_ff;
      case (state_ff)
         ST_MUL_R: begin
            mul_a = last_return_ff;
            mul_b = last_return_ff;
         end
         ST_MUL_L: begin
            mul_a = prev_return_ff;
            mul_b = prev_return_ff;
         end
         default: begin
            mul_a = last_return_ff;
            mul_b = prev_return_ff;
         end
      endcase
      mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   // effective window and the number of terms to sum
   always_comb begin
      if (window_ff < WINDOW_MIN) begin
         w_eff = WCMP_BITS'(WINDOW_SHORT);
      end else begin
         w_eff = WCMP_BITS'(window_ff);
      end
      if (w_eff > WIN_CAP) begin
         w_eff = WIN_CAP;
      end
      stored = WCMP_BITS'(seen_ff - SEEN_TWO);
      k_new  = (w_eff < stored) ? COUNT_BITS'(w_eff) : COUNT_BITS'(stored);
   end

   // ring indexing, term extension and divider operands
   always_comb begin
      new_return     = RET_BITS'({1'b0, req_price}) - RET_BITS'({1'b0, last_price_ff});
      ptr_next       = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
      sweep_next     = (sweep_addr_ff == '0) ? PTR_LAST : sweep_addr_ff - 1'b1;
      ram_wdata      = {cross_term_ff, energy_term_ff};
      rd_cross       = ram_rdata[RING_BITS-1:ENERGY_BITS];
      rd_energy      = ram_rdata[ENERGY_BITS-1:0];
      rd_cross_ext   = CSUM_BITS'(rd_cross);
      rd_energy_ext  = ESUM_BITS'(rd_energy);
      new_cross_ext  = CSUM_BITS'(cross_term_ff);
      new_energy_ext = ESUM_BITS'(energy_term_ff);
      neg            = cross_sum_ff[CSUM_BITS-1];
      mag            = neg ? CSUM_BITS'(0) - CSUM_BITS'(cross_sum_ff)
                           : CSUM_BITS'(cross_sum_ff);
      // times ten as eight plus two
      mag10          = (MAG10_BITS'(mag) << 3) + (MAG10_BITS'(mag) << 1);
      corr_rem0      = REM_BITS'(mag);
      str_rem0       = REM_BITS'(mag10 >> STR_PRE);
      den            = REM_BITS'(energy_sum_ff);
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[CSR_ADDR_BITS-1:2] == REG_WINDOW);

   // sequencer: next state and datapath control
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      window_in      = window_ff;
      last_price_in  = last_price_ff;
      last_return_in = last_return_ff;
      prev_return_in = prev_return_ff;
      seen_in        = seen_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      cross_sum_in   = cross_sum_ff;
      energy_sum_in  = energy_sum_ff;
      prod_in        = prod_ff;
      cross_term_in  = cross_term_ff;
      energy_term_in = energy_term_ff;
      sweep_addr_in  = sweep_addr_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      rd_pend_in     = 1'b0;
      rdy_in         = rdy_ff;
      corr_in        = corr_ff;
      str_in         = str_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_rdy_in     = rsp_rdy_ff;
      rsp_corr_in    = rsp_corr_ff;
      rsp_str_in     = rsp_str_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_raddr      = sweep_addr_ff;
      div_cmd        = '0;
      div_rem        = corr_rem0;
      div_feed       = '0;
      req_ready      = (state_ff == ST_IDLE);

      if (csr_write) begin
         window_in = csr_pwdata[WINDOW_BITS-1:0];
      end

      // drop the output item once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_price_in  = req_price;
               prev_return_in = last_return_ff;
               last_return_in = new_return;
               if (seen_ff < SEEN_MAX) begin
                  seen_in = seen_ff + 1'b1;
               end
               if (seen_ff < SEEN_TWO) begin
                  rdy_in   = 1'b0;
                  corr_in  = '0;
                  str_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL_X;
               end
            end
         end
         ST_MUL_X: begin
            prod_in  = mul_p;
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            cross_term_in = prod_ff[CROSS_BITS-1:0];
            prod_in       = mul_p;
            state_in      = ST_MUL_L;
         end
         ST_MUL_L: begin
            energy_term_in = ENERGY_BITS'(prod_ff);
            prod_in        = mul_p;
            state_in       = ST_PLAN;
         end
         ST_PLAN: begin
            // pick the cheapest way to move the window sums
            energy_term_in = energy_term_ff + ENERGY_BITS'(prod_ff);
            count_in       = k_new;
            if ((COUNT_BITS+1)'(k_new) == (COUNT_BITS+1)'(count_ff) + 1'b1) begin
               mode_in  = MODE_GROW;
               state_in = ST_STORE;
            end else if (k_new == count_ff) begin
               mode_in  = MODE_SLIDE;
               state_in = ST_OLD_RD;
            end else begin
               mode_in  = MODE_REBUILD;
               state_in = ST_STORE;
            end
         end
         ST_OLD_RD: begin
            // fetch the term leaving the window before its slot is reused
            ram_re    = 1'b1;
            ram_raddr = ring_back(ptr_ff, count_ff);
            state_in  = ST_OLD_SUB;
         end
         ST_OLD_SUB: begin
            cross_sum_in  = cross_sum_ff - rd_cross_ext;
            energy_sum_in = energy_sum_ff - rd_energy_ext;
            state_in      = ST_STORE;
         end
         ST_STORE: begin
            ram_we = 1'b1;
            ptr_in = ptr_next;
            if (mode_ff == MODE_REBUILD) begin
               cross_sum_in  = '0;
               energy_sum_in = '0;
               sweep_addr_in = ptr_ff;
               sweep_cnt_in  = '0;
               state_in      = ST_SWEEP;
            end else begin
               cross_sum_in  = cross_sum_ff + new_cross_ext;
               energy_sum_in = energy_sum_ff + new_energy_ext;
               state_in      = ST_CORR_START;
            end
         end
         ST_SWEEP: begin
            // read newest to oldest, add each term in the cycle after its read
            if (sweep_cnt_ff != count_ff) begin
               ram_re        = 1'b1;
               ram_raddr     = sweep_addr_ff;
               sweep_addr_in = sweep_next;
               sweep_cnt_in  = sweep_cnt_ff + 1'b1;
               rd_pend_in    = 1'b1;
            end
            if (rd_pend_ff) begin
               cross_sum_in  = cross_sum_ff + rd_cross_ext;
               energy_sum_in = energy_sum_ff + rd_energy_ext;
            end
            if (sweep_cnt_ff == count_ff && !rd_pend_ff) begin
               state_in = ST_CORR_START;
            end
         end
         ST_CORR_START: begin
            rdy_in = 1'b1;
            if (energy_sum_ff == '0) begin
               corr_in  = '0;
               str_in   = '0;
               state_in = ST_DONE;
            end else if (corr_rem0 >= den) begin
               corr_in  = neg ? RESULT_BITS'(-CORR_LIMIT) : RESULT_BITS'(CORR_LIMIT);
               state_in = ST_STR_START;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.steps = CORR_STEPS;
               div_rem       = corr_rem0;
               div_feed      = '0;
               state_in      = ST_CORR_DIV;
            end
         end
         ST_CORR_DIV: begin
            if (div_done) begin
               if (quotient > RESULT_BITS'(CORR_LIMIT)) begin
                  corr_in = neg ? RESULT_BITS'(-CORR_LIMIT) : RESULT_BITS'(CORR_LIMIT);
               end else begin
                  corr_in = neg ? RESULT_BITS'(0) - quotient : quotient;
               end
               state_in = ST_STR_START;
            end
         end
         ST_STR_START: begin
            if (str_rem0 >= den) begin
               str_in   = STR_LIMIT;
               state_in = ST_DONE;
            end else begin
               div_cmd.start = 1'b1;
               div_cmd.steps = STR_STEPS;
               div_rem       = str_rem0;
               div_feed      = QUO_BITS'(mag10[STR_PRE-1:0]) << STR_FRAC;
               state_in      = ST_STR_DIV;
            end
         end
         ST_STR_DIV: begin
            if (div_done) begin
               str_in   = (quotient > STR_LIMIT) ? STR_LIMIT : quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rdy_in   = rdy_ff;
               rsp_corr_in  = corr_ff;
               rsp_str_in   = str_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_ff      <= WINDOW_RESET;
         last_price_ff  <= '0;
         last_return_ff <= '0;
         seen_ff        <= '0;
         count_ff       <= '0;
         ptr_ff         <= '0;
         cross_sum_ff   <= '0;
         energy_sum_ff  <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_ff      <= window_in;
         last_price_ff  <= last_price_in;
         last_return_ff <= last_return_in;
         seen_ff        <= seen_in;
         count_ff       <= count_in;
         ptr_ff         <= ptr_in;
         cross_sum_ff   <= cross_sum_in;
         energy_sum_ff  <= energy_sum_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      prev_return_ff <= prev_return_in;
      prod_ff        <= prod_in;
      cross_term_ff  <= cross_term_in;
      energy_term_ff <= energy_term_in;
      sweep_addr_ff  <= sweep_addr_in;
      sweep_cnt_ff   <= sweep_cnt_in;
      rdy_ff         <= rdy_in;
      corr_ff        <= corr_in;
      str_ff         <= str_in;
      rsp_rdy_ff     <= rsp_rdy_in;
      rsp_corr_ff    <= rsp_corr_in;
      rsp_str_ff     <= rsp_str_in;
   end

   // term ring: cross and energy terms side by side
   wlrc_ram #(
      .WIDTH (RING_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ptr_ff),
      .write_data (ram_wdata),
      .read_en    (ram_re),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

   // shared fractional divider
   wlrc_div #(
      .REM_BITS (REM_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .div_cmd    (div_cmd),
      .rem_start  (div_rem),
      .divisor    (den),
      .feed_start (div_feed),
      .div_done   (div_done),
      .quotient   (quotient)
   );

   // ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ready_res   = rsp_rdy_ff;
   assign rsp_correlation = rsp_corr_ff;
   assign rsp_strength    = rsp_str_ff;
   assign csr_pready      = 1'b1;
   assign csr_prdata      = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_WINDOW)
                            ? CSR_DATA_BITS'(window_ff) : '0;

   // an accepted item keeps the block busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on two consecutive cycles");

   // a not-ready result carries zero correlation and strength
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready_res |-> rsp_correlation == '0 && rsp_strength == '0)
      else $error("not-ready result carries nonzero fields");

   // results stay inside their saturation limits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_strength > STR_LIMIT) && !(rsp_correlation > CORR_LIMIT)
                    && !(rsp_correlation < -CORR_LIMIT))
      else $error("result outside saturation limits");

   // the summed term count never exceeds the ring depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_WINDOW))
      else $error("window term count exceeds ring depth");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the lag-one return correlator
// Drives closing prices through the request channel with random gaps, takes
// results with random back-pressure, and checks every result against a
// cycle-free model of the window sums and the two scaled quotients. The
// window length register is rewritten between phases and read back.
// ----------------------------------------------------------------------------
module tb_top;
   import wlrc_pkg::*;

   localparam int PRICE_W    = 24;
   localparam int MAX_TERMS  = 256;
   localparam int SEEN_CAP   = MAX_TERMS + 2;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 110;
   localparam logic [CSR_ADDR_BITS-1:0] WINDOW_ADDR = CSR_ADDR_BITS'(4 * REG_WINDOW);
   localparam logic [PRICE_W-1:0] PRICE_TOP = {PRICE_W{1'b1}};

   typedef struct packed {
      logic                          ready_res;
      logic signed [RESULT_BITS-1:0] correlation;
      logic [RESULT_BITS-1:0]        strength;
   } corr_result_t;

   typedef enum logic [2:0] {
      WALK_SMALL,
      WALK_LARGE,
      TREND,
      ZIGZAG,
      FLAT,
      JUMP
   } price_pattern_t;

   // DUT ports
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [PRICE_W-1:0]            req_price = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_ready_res;
   logic signed [RESULT_BITS-1:0] rsp_correlation;
   logic [RESULT_BITS-1:0]        rsp_strength;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]      csr_prdata;
   logic                          csr_pready;

   // model state
   logic [PRICE_W-1:0]    prev_price = '0;
   logic signed [PRICE_W:0] prev_return = '0;
   logic signed [48:0]    cross_terms [MAX_TERMS];
   logic [49:0]           energy_terms [MAX_TERMS];
   logic [7:0]            term_ptr = '0;
   int unsigned           prices_seen = 0;
   logic [WINDOW_BITS-1:0] window_setting = WINDOW_RESET;

   corr_result_t expected_results [$];
   int          mismatches = 0;
   int          stall_cycles = 0;
   logic        idling_on = 1'b1;
   logic [PRICE_W-1:0] last_sent = '0;

   windowed_lag1_return_correlation DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_price       (req_price),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ready_res   (rsp_ready_res),
      .rsp_correlation (rsp_correlation),
      .rsp_strength    (rsp_strength),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Advance the return model by one price and work out its result
   function automatic corr_result_t predict_correlation(input logic [PRICE_W-1:0] price);
      logic signed [PRICE_W:0] ret;
      int unsigned             span;
      int unsigned             win;
      logic [7:0]              idx;
      logic signed [63:0]      cross_sum;
      logic [63:0]             energy_sum;
      logic [63:0]             mag;
      logic                    neg;
      logic [127:0]            quo;
      corr_result_t            res;
      ret = $signed({1'b0, price}) - $signed({1'b0, prev_price});
      if (prices_seen < SEEN_CAP) prices_seen++;
      if (prices_seen >= 3) begin
         cross_terms[term_ptr]  = ret * prev_return;
         energy_terms[term_ptr] = ret * ret + prev_return * prev_return;
         term_ptr = term_ptr + 8'd1;
      end
      prev_return = ret;
      prev_price  = price;
      res = '0;
      if (prices_seen < 3) return res;

      // clamp the window, then sum the newest terms
      win = window_setting;
      if (win < WINDOW_MIN) win = WINDOW_SHORT;
      if (win > MAX_TERMS) win = MAX_TERMS;
      span = (win < prices_seen - 2) ? win : prices_seen - 2;
      cross_sum  = '0;
      energy_sum = '0;
      for (int j = 0; j < span; j++) begin
         idx = term_ptr - 8'(j) - 8'd1;
         cross_sum  += cross_terms[idx];
         energy_sum += energy_terms[idx];
      end

      res.ready_res = 1'b1;
      if (energy_sum != 0) begin
         neg = cross_sum[63];
         mag = neg ? $unsigned(-cross_sum) : $unsigned(cross_sum);
         quo = ({64'd0, mag} << 15) / {64'd0, energy_sum};
         if (quo > 128'(CORR_LIMIT)) quo = 128'(CORR_LIMIT);
         res.correlation = neg ? RESULT_BITS'(-quo[15:0]) : quo[15:0];
         quo = ({64'd0, mag * 64'd10} << STR_FRAC) / {64'd0, energy_sum};
         if (quo > 128'(STR_LIMIT)) quo = 128'(STR_LIMIT);
         res.strength = quo[15:0];
      end
      return res;
   endfunction

   // Send one price, with an optional leading gap, and record its result
   task automatic send_price(input logic [PRICE_W-1:0] price);
      int gap;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_price <= price;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_correlation(price));
      last_sent = price;
   endtask

   // Drop valid and hold until every outstanding result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // One register access: setup cycle, then access until pready
   task automatic csr_access(input logic is_write, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_window_readback(input logic [WINDOW_BITS-1:0] want);
      logic [CSR_DATA_BITS-1:0] rdata;
      csr_access(1'b0, WINDOW_ADDR, '0, rdata);
      if (rdata[WINDOW_BITS-1:0] !== want) begin
         $error("window_length mismatch: expected %0d actual %0d",
                want, rdata[WINDOW_BITS-1:0]);
         mismatches++;
      end
   endtask

   // Write the window length with random upper bits, then read it back
   task automatic set_window(input logic [WINDOW_BITS-1:0] win);
      logic [CSR_DATA_BITS-1:0] rdata;
      csr_access(1'b1, WINDOW_ADDR,
                 {(CSR_DATA_BITS-WINDOW_BITS)'($urandom), win}, rdata);
      window_setting = win;
      check_window_readback(win);
   endtask

   task automatic test_reset_value();
      check_window_readback(WINDOW_RESET);
   endtask

   // First two prices are not ready, the third is
   task automatic test_warmup();
      send_price('0);
      send_price(PRICE_TOP);
      send_price('0);
   endtask

   // Full-scale swings and single-tick trends both ways
   task automatic test_extremes();
      send_price(PRICE_TOP);
      send_price('0);
      send_price(PRICE_TOP);
      for (int i = 1; i <= 3; i++) send_price(PRICE_TOP - PRICE_W'(i));
      for (int i = 1; i <= 3; i++) send_price(PRICE_TOP - PRICE_W'(4 - i));
      drain_results();
   endtask

   // Flat prices fill a short window with zero terms
   task automatic test_zero_energy();
      set_window(WINDOW_MIN);
      repeat (6) send_price(PRICE_W'(24'h5A5A5A));
      drain_results();
   endtask

   // Window values below the minimum fall back to the default
   task automatic test_short_window();
      logic [WINDOW_BITS-1:0] wins [3] = '{9'd0, 9'd1, 9'd3};
      foreach (wins[i]) begin
         set_window(wins[i]);
         send_price(PRICE_W'($urandom));
         send_price(PRICE_W'($urandom));
         drain_results();
      end
   endtask

   // Windows at and above the ring size are clamped
   task automatic test_long_window();
      logic [WINDOW_BITS-1:0] wins [3] = '{9'd511, 9'd256, 9'd300};
      foreach (wins[i]) begin
         set_window(wins[i]);
         send_price(PRICE_W'($urandom));
         drain_results();
      end
   endtask

   // Price runs of mixed shape: walks, trends, zigzags, flats and jumps
   task automatic run_random_phase(input int count, input logic [WINDOW_BITS-1:0] win);
      price_pattern_t pattern;
      int             run_left;
      longint         step;
      longint         p;
      set_window(win);
      run_left = 0;
      pattern  = WALK_SMALL;
      step     = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2: pattern = WALK_SMALL;
               3, 4:    pattern = WALK_LARGE;
               5:       pattern = TREND;
               6:       pattern = ZIGZAG;
               7:       pattern = FLAT;
               default: pattern = JUMP;
            endcase
            run_left = $urandom_range(4, 40);
            step = longint'($urandom_range(0, 1 << $urandom_range(1, 17))) - (1 << 8);
         end
         case (pattern)
            WALK_SMALL: p = longint'(last_sent) + longint'($urandom_range(0, 30)) - 15;
            WALK_LARGE: p = longint'(last_sent) + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            TREND:      p = longint'(last_sent) + step;
            ZIGZAG:     p = longint'(last_sent) + ((i % 2) ? step : -step);
            FLAT:       p = longint'(last_sent);
            default:    p = longint'($urandom_range(0, PRICE_TOP));
         endcase
         if (p < 0) p = 0;
         if (p > longint'(PRICE_TOP)) p = longint'(PRICE_TOP);
         send_price(PRICE_W'(p));
         run_left--;
      end
      drain_results();
   endtask

   task automatic test_random();
      logic [WINDOW_BITS-1:0] wins [7] = '{9'd4, 9'd255, 9'd17, 9'd0, 9'd256, 9'd511, 9'd100};
      foreach (wins[i]) run_random_phase(PHASE_ITEMS, wins[i]);
      // last stretch runs without idling on either side
      idling_on = 1'b0;
      run_random_phase(PHASE_ITEMS, WINDOW_BITS'($urandom_range(0, 511)));
   endtask

   // Result side back-pressure in random bursts
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      corr_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no item waiting: ready_res %0d correlation %0d strength %0d",
                   rsp_ready_res, rsp_correlation, rsp_strength);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_ready_res !== want.ready_res) begin
               $error("ready_res mismatch: expected %0d actual %0d",
                      want.ready_res, rsp_ready_res);
               mismatches++;
            end
            if (rsp_correlation !== want.correlation) begin
               $error("correlation mismatch: expected %0d actual %0d",
                      want.correlation, rsp_correlation);
               mismatches++;
            end
            if (rsp_strength !== want.strength) begin
               $error("strength mismatch: expected %0d actual %0d",
                      want.strength, rsp_strength);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: count cycles with no handshake on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_value();
      test_warmup();
      test_extremes();
      test_zero_energy();
      test_short_window();
      test_long_window();
      test_random();
      drain_results();
      repeat (64) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
src/wlrc_pkg.sv
src/wlrc_ram.sv
src/wlrc_div.sv
src/windowed_lag1_return_correlation.sv
tb/tb_top.sv
